// File: sv/quadrature_step_counter_defines.svh
// Assertion macros shared by the quadrature step counter RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef QUADRATURE_STEP_COUNTER_DEFINES_SVH
`define QUADRATURE_STEP_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quadrature_step_counter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define QSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quadrature_step_counter: next-cycle check failed");

`endif

// File: sv/qsc_pkg.sv
// Package for the quadrature step counter: operation codes, register indexes,
// reset defaults and the edge decoder control struct. No dependencies.
`timescale 1ns / 1ps

package qsc_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_TRANSITION = 2'd0;
  localparam logic [1:0] OP_CAPTURE    = 2'd1;
  localparam logic [1:0] OP_ZERO       = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_REV_STEPS         = 2'd0;
  localparam logic [1:0] REG_COUNT_ALL_EDGES   = 2'd1;
  localparam logic [1:0] REG_REVERSE_DIRECTION = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE_TICKS    = 2'd3;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [14:0] REV_STEPS_RESET   = 15'd24;
  localparam int          TIME_BITS_DEFAULT = 28;

  // Direction in which the current quadrature cycle was entered.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } cycle_dir_t;

  typedef struct packed {
    logic       count;     // a step is counted for this edge
    logic       up;        // counted step goes up
    cycle_dir_t dir_next;  // cycle direction after this edge
  } edge_ctl_t;

endpackage

// File: sv/qsc_edge_decode.sv
// Quadrature edge decoder: classifies a transition between Gray-code phases
// and decides whether it counts. Depends on qsc_pkg.
`timescale 1ns / 1ps

module qsc_edge_decode (
  input  logic                  prev_a,
  input  logic                  prev_b,
  input  logic                  curr_a,
  input  logic                  curr_b,
  input  logic                  count_all_edges,
  input  logic                  reverse_direction,
  input  qsc_pkg::cycle_dir_t   cycle_dir,
  output qsc_pkg::edge_ctl_t    ctl
);
  import qsc_pkg::*;

  logic [1:0] from_phase;
  logic [1:0] to_phase;
  logic       fwd;
  logic       bwd;

  // Phase order A0B0, A1B0, A1B1, A0B1: phase = {a^b... } mapped explicitly.
  function automatic logic [1:0] phase_of(input logic a, input logic b);
    logic [1:0] p;
    unique case ({a, b})
      2'b00:   p = 2'd0;
      2'b10:   p = 2'd1;
      2'b11:   p = 2'd2;
      default: p = 2'd3;
    endcase
    return p;
  endfunction

  assign from_phase = phase_of(prev_a, prev_b);
  assign to_phase   = phase_of(curr_a, curr_b);
  assign fwd        = (to_phase == from_phase + 2'd1);
  assign bwd        = (to_phase == from_phase - 2'd1);

  always_comb begin
    ctl.count    = 1'b0;
    ctl.up       = !reverse_direction;
    ctl.dir_next = cycle_dir;
    if (fwd) begin
      ctl.up = !reverse_direction;
      if (from_phase == 2'd1) begin
        // Closing a forward cycle counts only if it was opened forward, or in all-edge mode.
        ctl.count    = count_all_edges || (cycle_dir == DIR_INC);
        ctl.dir_next = DIR_NONE;
      end else begin
        ctl.count = count_all_edges;
        if (from_phase == 2'd2) begin
          ctl.dir_next = DIR_INC;
        end
      end
    end else if (bwd) begin
      ctl.up = reverse_direction;
      if (from_phase == 2'd3) begin
        ctl.count    = count_all_edges || (cycle_dir == DIR_DEC);
        ctl.dir_next = DIR_NONE;
      end else begin
        ctl.count = count_all_edges;
        if (from_phase == 2'd2) begin
          ctl.dir_next = DIR_DEC;
        end
      end
    end
  end

endmodule

// File: sv/quadrature_step_counter.sv
// Quadrature step counter: one result beat per input beat, registered in the
// cycle after acceptance. A new beat is accepted every cycle through the single
// state-update register stage, and the input side stalls only while a
// result is held back by the output side.
// Synchronous reset clears all counters and internal times, loads register
// defaults and clears out_valid, not capture outputs; no clearing pass is needed.
`timescale 1ns / 1ps

module quadrature_step_counter #(
  parameter int TIME_BITS = qsc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [qsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [qsc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic                                prev_a,
  input  logic                                prev_b,
  input  logic                                curr_a,
  input  logic                                curr_b,
  input  logic [27:0]                         elapsed_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  position_count,
  output logic [14:0]                         step_in_turn,
  output logic signed [15:0]                  turn_count,
  output logic signed [31:0]                  capture_change,
  output logic [30:0]                         capture_time,
  output logic                                level_a,
  output logic                                level_b
);
  import qsc_pkg::*;

  `include "quadrature_step_counter_defines.svh"

  localparam logic [31:0] TimeMask = (32'd1 << TIME_BITS) - 32'd1;
  localparam logic [30:0] TimeSat  = 31'h7FFF_FFFF;

  // Configuration registers.
  logic [14:0] rev_steps;
  logic        count_all_edges;
  logic        reverse_direction;
  logic [9:0]  debounce_ticks;

  // Internal state; position, step, turns and levels live in the output ports.
  logic [30:0] pending_time;
  logic [30:0] accum_time;
  cycle_dir_t  cycle_dir;
  logic [31:0] count_at_capture;

  logic [31:0] total_count_next;
  logic [14:0] step_pos_next;
  logic [15:0] turns_next;
  logic [30:0] pending_time_next;
  logic [30:0] accum_time_next;
  cycle_dir_t  cycle_dir_next;
  logic [31:0] count_at_capture_next;
  logic [31:0] capture_change_next;
  logic [30:0] capture_time_next;
  logic        level_a_next;
  logic        level_b_next;

  edge_ctl_t   ctl;
  logic        accept;

  // Short names for the checks at the end.
  logic        beat_transition;
  logic        beat_capture;
  logic        beat_zero;
  logic        caps_zero;
  logic        counts_zero;
  logic [1:0]  levels_in;
  logic [1:0]  levels_out;

  function automatic logic [30:0] sat_add(input logic [30:0] x, input logic [30:0] y);
    logic [31:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[31] ? TimeSat : s[30:0];
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  qsc_edge_decode u_decode (
    .prev_a            (prev_a),
    .prev_b            (prev_b),
    .curr_a            (curr_a),
    .curr_b            (curr_b),
    .count_all_edges   (count_all_edges),
    .reverse_direction (reverse_direction),
    .cycle_dir         (cycle_dir),
    .ctl               (ctl)
  );

  always_comb begin
    logic [31:0] ticks_masked;
    logic [30:0] t_edge;
    logic [30:0] t_total;
    logic [14:0] cpr;
    logic [15:0] step_inc;

    ticks_masked = {4'd0, elapsed_ticks} & TimeMask;
    t_edge   = sat_add(ticks_masked[30:0], {21'd0, debounce_ticks});
    t_total  = count_all_edges ? t_edge : sat_add(t_edge, pending_time);
    cpr      = (rev_steps == 15'd0) ? 15'd1 : rev_steps;
    step_inc = {1'b0, step_in_turn} + 16'd1;

    total_count_next      = position_count;
    step_pos_next         = step_in_turn;
    turns_next            = turn_count;
    pending_time_next     = pending_time;
    accum_time_next       = accum_time;
    cycle_dir_next        = cycle_dir;
    count_at_capture_next = count_at_capture;
    capture_change_next   = 32'd0;
    capture_time_next     = 31'd0;
    level_a_next          = level_a;
    level_b_next          = level_b;

    unique case (operation)
      OP_TRANSITION: begin
        level_a_next   = curr_a;
        level_b_next   = curr_b;
        cycle_dir_next = ctl.dir_next;
        if (!count_all_edges) begin
          pending_time_next = t_total;
        end
        if (ctl.count) begin
          pending_time_next = 31'd0;
          accum_time_next   = sat_add(accum_time, t_total);
          if (ctl.up) begin
            total_count_next = position_count + 32'sd1;
            if (step_inc >= {1'b0, cpr}) begin
              step_pos_next = 15'(step_inc - {1'b0, cpr});
              turns_next    = turn_count + 16'sd1;
            end else begin
              step_pos_next = step_inc[14:0];
            end
          end else begin
            total_count_next = position_count - 32'sd1;
            if (step_in_turn == 15'd0) begin
              step_pos_next = cpr - 15'd1;
              turns_next    = turn_count - 16'sd1;
            end else begin
              step_pos_next = step_in_turn - 15'd1;
            end
          end
        end
      end
      OP_CAPTURE: begin
        capture_change_next   = position_count - count_at_capture;
        count_at_capture_next = position_count;
        capture_time_next     = accum_time;
        accum_time_next       = 31'd0;
      end
      OP_ZERO: begin
        total_count_next      = 32'd0;
        step_pos_next         = 15'd0;
        turns_next            = 16'd0;
        pending_time_next     = 31'd0;
        accum_time_next       = 31'd0;
        cycle_dir_next        = DIR_NONE;
        count_at_capture_next = 32'd0;
      end
      default: begin
        // Unused code: state is reported unchanged.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rev_steps         <= REV_STEPS_RESET;
      count_all_edges   <= 1'b0;
      reverse_direction <= 1'b0;
      debounce_ticks    <= 10'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_REV_STEPS:         rev_steps         <= cfg_data;
        REG_COUNT_ALL_EDGES:   count_all_edges   <= cfg_data[0];
        REG_REVERSE_DIRECTION: reverse_direction <= cfg_data[0];
        REG_DEBOUNCE_TICKS:    debounce_ticks    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // The state registers double as the result register: they change only on
  // an accepted beat, which happens only when the previous result is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      position_count   <= 32'sd0;
      step_in_turn     <= 15'd0;
      turn_count       <= 16'sd0;
      pending_time     <= 31'd0;
      accum_time       <= 31'd0;
      cycle_dir        <= DIR_NONE;
      count_at_capture <= 32'd0;
      level_a          <= 1'b0;
      level_b          <= 1'b0;
    end else begin
      if (accept) begin
        out_valid        <= 1'b1;
        position_count   <= total_count_next;
        step_in_turn     <= step_pos_next;
        turn_count       <= turns_next;
        pending_time     <= pending_time_next;
        accum_time       <= accum_time_next;
        cycle_dir        <= cycle_dir_next;
        count_at_capture <= count_at_capture_next;
        level_a          <= level_a_next;
        level_b          <= level_b_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      capture_change <= capture_change_next;
      capture_time   <= capture_time_next;
    end
  end

  assign beat_transition = accept && (operation == OP_TRANSITION);
  assign beat_capture    = accept && (operation == OP_CAPTURE);
  assign beat_zero       = accept && (operation == OP_ZERO);
  assign caps_zero       = (capture_change == 32'sd0) && (capture_time == 31'd0);
  assign counts_zero     = (position_count == 32'sd0) && (step_in_turn == 15'd0) &&
                           (turn_count == 16'sd0);
  assign levels_in       = {curr_a, curr_b};
  assign levels_out      = {level_a, level_b};

  `QSC_ASSERT_NEXT(a_nocap_zero, accept && !beat_capture, caps_zero)
  `QSC_ASSERT_NEXT(a_zero_clears, beat_zero, counts_zero)
  `QSC_ASSERT_NEXT(a_levels_follow, beat_transition, out_valid && (levels_out == $past(levels_in)))
  `QSC_ASSERT_NOW(a_capture_clears, out_valid && (capture_time != 31'd0), accum_time == 31'd0)

endmodule

// File: sim/quadrature_step_counter_tb.sv
// Self-checking testbench for quadrature_step_counter: random valid/ready traffic
// on both channels, with a beat-level predictor of the count, revolution and time state.
// Depends on qsc_pkg and the quadrature_step_counter RTL only.
`timescale 1ns / 1ps

module quadrature_step_counter_tb;
  import qsc_pkg::*;

  localparam logic [1:0]  OP_UNUSED          = 2'd3;
  localparam logic [1:0]  PHASE_A0B0         = 2'd0;
  localparam logic [1:0]  PHASE_A1B0         = 2'd1;
  localparam logic [1:0]  PHASE_A1B1         = 2'd2;
  localparam logic [1:0]  PHASE_A0B1         = 2'd3;
  localparam logic [30:0] TIME_FULL          = 31'h7FFF_FFFF;
  localparam logic [27:0] TICKS_MAX          = 28'hFFF_FFFF;
  localparam int          SETTINGS_TOTAL     = 9;
  localparam int          RANDOM_PER_SETTING = 195;
  localparam int          LIMIT_CYCLES       = 200_000;

  typedef struct packed {
    logic [1:0]  op;
    logic        pa;
    logic        pb;
    logic        ca;
    logic        cb;
    logic [27:0] ticks;
  } enc_beat_t;

  typedef struct {
    logic [31:0] position;
    logic [14:0] step;
    logic [15:0] turns;
    logic [31:0] change;
    logic [30:0] ctime;
    logic        la;
    logic        lb;
  } enc_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_REV_STEPS;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_TRANSITION;
  logic        prev_a = 1'b0;
  logic        prev_b = 1'b0;
  logic        curr_a = 1'b0;
  logic        curr_b = 1'b0;
  logic [27:0] elapsed_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] position_count;
  logic [14:0]        step_in_turn;
  logic signed [15:0] turn_count;
  logic signed [31:0] capture_change;
  logic [30:0]        capture_time;
  logic               level_a;
  logic               level_b;

  quadrature_step_counter u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .prev_a         (prev_a),
    .prev_b         (prev_b),
    .curr_a         (curr_a),
    .curr_b         (curr_b),
    .elapsed_ticks  (elapsed_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .position_count (position_count),
    .step_in_turn   (step_in_turn),
    .turn_count     (turn_count),
    .capture_change (capture_change),
    .capture_time   (capture_time),
    .level_a        (level_a),
    .level_b        (level_b)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the register file and the decoder state.
  logic [14:0] cfg_cpr = REV_STEPS_RESET;
  logic        cfg_all_edges = 1'b0;
  logic        cfg_reverse = 1'b0;
  logic [9:0]  cfg_debounce = '0;

  logic [31:0] pred_count = '0;
  logic [14:0] pred_step = '0;
  logic [15:0] enc_turns = '0;
  logic [30:0] idle_time = '0;
  logic [30:0] run_time = '0;
  cycle_dir_t  cycle_dir = DIR_NONE;
  logic [31:0] capture_base = '0;
  logic [1:0]  enc_levels = '0;

  enc_beat_t   pending_beats[$];
  enc_report_t expected_reports[$];
  enc_beat_t   beat_on_wire;
  logic [1:0]  walk_phase = PHASE_A0B0;
  logic        walk_forward = 1'b1;
  logic        steady = 1'b0;

  int mismatches = 0;
  int beats_accepted = 0;
  int results_checked = 0;
  int steps_counted = 0;
  int captures_seen = 0;
  int saturated_captures = 0;
  int cycle_count = 0;

  function automatic logic [30:0] time_sum(logic [30:0] x, logic [30:0] y);
    logic [31:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[31] ? TIME_FULL : s[30:0];
  endfunction

  function automatic logic [1:0] gray_phase(logic a, logic b);
    case ({a, b})
      2'b00:   return PHASE_A0B0;
      2'b10:   return PHASE_A1B0;
      2'b11:   return PHASE_A1B1;
      default: return PHASE_A0B1;
    endcase
  endfunction

  function automatic logic [1:0] phase_levels(logic [1:0] p);
    case (p)
      PHASE_A0B0: return 2'b00;
      PHASE_A1B0: return 2'b10;
      PHASE_A1B1: return 2'b11;
      default:    return 2'b01;
    endcase
  endfunction

  function automatic void count_step(logic [30:0] t, logic up);
    logic [15:0] rev;
    logic [15:0] next_step;
    rev = (cfg_cpr == '0) ? 16'd1 : {1'b0, cfg_cpr};
    if (up) begin
      pred_count = pred_count + 32'd1;
      next_step = {1'b0, pred_step} + 16'd1;
      // Only one subtraction, so a step left above a shrunken revolution stays high.
      if (next_step >= rev) begin
        next_step = next_step - rev;
        enc_turns = enc_turns + 16'd1;
      end
    end else begin
      pred_count = pred_count - 32'd1;
      if (pred_step == '0) begin
        next_step = rev - 16'd1;
        enc_turns = enc_turns - 16'd1;
      end else begin
        next_step = {1'b0, pred_step} - 16'd1;
      end
    end
    pred_step = next_step[14:0];
    idle_time = '0;
    run_time = time_sum(run_time, t);
    steps_counted++;
  endfunction

  function automatic enc_report_t decode_beat(enc_beat_t b);
    enc_report_t r;
    logic [1:0]  from_ph;
    logic [1:0]  to_ph;
    logic [30:0] t;
    logic        up;
    r.change = '0;
    r.ctime = '0;
    case (b.op)
      OP_TRANSITION: begin
        from_ph = gray_phase(b.pa, b.pb);
        to_ph = gray_phase(b.ca, b.cb);
        up = !cfg_reverse;
        t = time_sum({3'b0, b.ticks}, {21'b0, cfg_debounce});
        enc_levels = {b.ca, b.cb};
        // In full-cycle mode the time of every edge is carried until a step counts.
        if (!cfg_all_edges) begin
          t = time_sum(t, idle_time);
          idle_time = t;
        end
        if (to_ph == from_ph + 2'd1) begin
          if (from_ph == PHASE_A1B0) begin
            if (cfg_all_edges || cycle_dir == DIR_INC) count_step(t, up);
            cycle_dir = DIR_NONE;
          end else begin
            if (cfg_all_edges) count_step(t, up);
            if (from_ph == PHASE_A1B1) cycle_dir = DIR_INC;
          end
        end else if (to_ph == from_ph - 2'd1) begin
          if (from_ph == PHASE_A0B1) begin
            if (cfg_all_edges || cycle_dir == DIR_DEC) count_step(t, !up);
            cycle_dir = DIR_NONE;
          end else begin
            if (cfg_all_edges) count_step(t, !up);
            if (from_ph == PHASE_A1B1) cycle_dir = DIR_DEC;
          end
        end
      end
      OP_CAPTURE: begin
        r.change = pred_count - capture_base;
        capture_base = pred_count;
        r.ctime = run_time;
        run_time = '0;
        captures_seen++;
        if (r.ctime == TIME_FULL) saturated_captures++;
      end
      OP_ZERO: begin
        pred_count = '0;
        pred_step = '0;
        enc_turns = '0;
        idle_time = '0;
        run_time = '0;
        cycle_dir = DIR_NONE;
        capture_base = '0;
      end
      default: begin
      end
    endcase
    r.position = pred_count;
    r.step = pred_step;
    r.turns = enc_turns;
    r.la = enc_levels[1];
    r.lb = enc_levels[0];
    return r;
  endfunction

  function automatic enc_beat_t mk_beat(logic [1:0] op, logic [1:0] from_ph, logic [1:0] to_ph,
                                        logic [27:0] ticks);
    enc_beat_t b;
    b.op = op;
    {b.pa, b.pb} = phase_levels(from_ph);
    {b.ca, b.cb} = phase_levels(to_ph);
    b.ticks = ticks;
    return b;
  endfunction

  // Mostly a shaft walking through legal edges, with illegal and scrambled edges mixed in.
  function automatic enc_beat_t random_beat();
    enc_beat_t  b;
    logic [1:0] nxt;
    int         roll;
    roll = $urandom_range(99);
    b.op = OP_TRANSITION;
    case ($urandom_range(9))
      0:       b.ticks = 28'($urandom());
      1:       b.ticks = TICKS_MAX;
      2:       b.ticks = '0;
      default: b.ticks = 28'($urandom_range(300));
    endcase
    {b.pa, b.pb} = phase_levels(walk_phase);
    if (roll < 6) begin
      if (roll < 4) b.op = OP_CAPTURE;
      else if (roll < 5) b.op = OP_ZERO;
      else b.op = OP_UNUSED;
      {b.pa, b.pb, b.ca, b.cb} = 4'($urandom_range(15));
    end else if (roll < 12) begin
      nxt = ($urandom_range(1) == 0) ? walk_phase : walk_phase + 2'd2;
      {b.ca, b.cb} = phase_levels(nxt);
      walk_phase = nxt;
    end else if (roll < 15) begin
      {b.pa, b.pb, b.ca, b.cb} = 4'($urandom_range(15));
      walk_phase = gray_phase(b.ca, b.cb);
    end else begin
      if ($urandom_range(9) == 0) walk_forward = !walk_forward;
      nxt = walk_forward ? walk_phase + 2'd1 : walk_phase - 2'd1;
      {b.ca, b.cb} = phase_levels(nxt);
      walk_phase = nxt;
    end
    return b;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic load_setting(logic [14:0] cpr, logic all, logic rev, logic [9:0] deb);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_REV_STEPS;
    cfg_data <= cpr;
    @(posedge clk);
    cfg_index <= REG_COUNT_ALL_EDGES;
    cfg_data <= {14'd0, all};
    @(posedge clk);
    cfg_index <= REG_REVERSE_DIRECTION;
    cfg_data <= {14'd0, rev};
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE_TICKS;
    cfg_data <= {5'd0, deb};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_cpr = cpr;
    cfg_all_edges = all;
    cfg_reverse = rev;
    cfg_debounce = deb;
  endtask

  // Sampled on the falling edge so the clocked blocks have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Driver: a beat is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(decode_beat(beat_on_wire));
        beats_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
          beat_on_wire = pending_beats.pop_front();
          operation <= beat_on_wire.op;
          prev_a <= beat_on_wire.pa;
          prev_b <= beat_on_wire.pb;
          curr_a <= beat_on_wire.ca;
          curr_b <= beat_on_wire.cb;
          elapsed_ticks <= beat_on_wire.ticks;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    enc_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("result beat with nothing expected", position_count, '0);
        end else begin
          want = expected_reports.pop_front();
          results_checked++;
          if (position_count !== want.position)
            flag_mismatch("position_count", position_count, want.position);
          if (step_in_turn !== want.step)
            flag_mismatch("step_in_turn", {17'd0, step_in_turn}, {17'd0, want.step});
          if (turn_count !== want.turns)
            flag_mismatch("turn_count", {16'd0, turn_count}, {16'd0, want.turns});
          if (capture_change !== want.change)
            flag_mismatch("capture_change", capture_change, want.change);
          if (capture_time !== want.ctime)
            flag_mismatch("capture_time", {1'b0, capture_time}, {1'b0, want.ctime});
          if (level_a !== want.la)
            flag_mismatch("level_a", {31'd0, level_a}, {31'd0, want.la});
          if (level_b !== want.lb)
            flag_mismatch("level_b", {31'd0, level_b}, {31'd0, want.lb});
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [14:0] rnd_cpr;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: full-cycle counting, 24 steps per revolution.
    pending_beats.push_back(mk_beat(OP_ZERO, PHASE_A0B0, PHASE_A0B0, '0));
    pending_beats.push_back(mk_beat(OP_UNUSED, PHASE_A1B1, PHASE_A1B1, TICKS_MAX));
    pending_beats.push_back(mk_beat(OP_CAPTURE, PHASE_A0B0, PHASE_A0B0, '0));
    // A forward cycle counts on its final edge, a backward one likewise.
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B1, PHASE_A0B1, 28'd1));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A0B1, PHASE_A0B0, 28'd2));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A0B0, PHASE_A1B0, 28'd3));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B0, PHASE_A1B1, 28'd4));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B1, PHASE_A1B0, 28'd5));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B0, PHASE_A0B0, 28'd6));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A0B0, PHASE_A0B1, 28'd7));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A0B1, PHASE_A1B1, 28'd8));
    // Illegal edges: no change, then both channels at once.
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B1, PHASE_A1B1, 28'd9));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B1, PHASE_A0B0, 28'd10));
    pending_beats.push_back(mk_beat(OP_CAPTURE, PHASE_A0B0, PHASE_A0B0, '0));
    // Enough full-scale gaps to saturate the carried and the captured time.
    repeat (5) pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B1, PHASE_A1B1, TICKS_MAX));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B1, PHASE_A0B1, TICKS_MAX));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A0B1, PHASE_A0B0, TICKS_MAX));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A0B0, PHASE_A1B0, TICKS_MAX));
    pending_beats.push_back(mk_beat(OP_TRANSITION, PHASE_A1B0, PHASE_A1B1, TICKS_MAX));
    pending_beats.push_back(mk_beat(OP_CAPTURE, PHASE_A1B1, PHASE_A1B1, '0));
    walk_phase = PHASE_A1B1;
    wait_idle();

    for (int ph = 1; ph <= SETTINGS_TOTAL; ph++) begin
      rnd_cpr = ($urandom_range(3) == 0) ? 15'($urandom_range(32767, 1))
                                         : 15'($urandom_range(40, 1));
      case (ph)
        1:       load_setting(15'd32767, 1'b1, 1'b0, 10'd1023);
        2:       load_setting(15'd0, 1'b0, 1'b1, 10'd0);
        3:       load_setting(15'd1, 1'b1, 1'b1, 10'd1023);
        4:       load_setting(15'd5, 1'b0, 1'b0, 10'd7);
        5:       load_setting(15'd3, 1'b1, 1'b0, 10'd0);
        default: load_setting(rnd_cpr, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              10'($urandom_range(1023)));
      endcase
      @(negedge clk);
      // One setting runs back to back with no idle cycles on either side.
      steady = (ph == 4);
      repeat (RANDOM_PER_SETTING) pending_beats.push_back(random_beat());
      wait_idle();
    end
    steady = 1'b0;

    $display("Ran %0d beats over %0d register settings, %0d results checked.",
             beats_accepted, SETTINGS_TOTAL + 1, results_checked);
    $display("Counted %0d steps and %0d captures, %0d of them with saturated time.",
             steps_counted, captures_seen, saturated_captures);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
